// File: design/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg
// shared types and constants of the sorted table interpolator
// ----------------------------------------------------------------------------
package stip_pkg;

  localparam int MaxPointsDef = 1024;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_FRACTION = 3'd1;
  localparam logic [2:0] CFG_POINTS   = 3'd2;
  localparam logic [2:0] CFG_LOW      = 3'd3;
  localparam logic [2:0] CFG_HIGH     = 3'd4;
  localparam logic [2:0] CFG_OUTSIDE  = 3'd5;

  typedef enum logic [1:0] {
    CLS_LOAD,
    CLS_QUERY,
    CLS_MISS
  } cls_e;

  typedef struct packed {
    cls_e               cls;
    logic [9:0]         position;
    logic signed [31:0] key_value;
    logic signed [31:0] data_value;
    logic               key_missing;
    logic               data_missing;
  } item_t;

  typedef struct packed {
    logic               interpolation_mode;
    logic [16:0]        step_fraction;
    logic [10:0]        points_used;
    logic signed [31:0] low_value;
    logic signed [31:0] high_value;
    logic               outside_missing;
  } cfg_t;

endpackage

// File: design/stip_front.sv
// ----------------------------------------------------------------------------
// stip_front
// input register, classifies each beat and drops loads beyond the table
// ----------------------------------------------------------------------------
module stip_front #(
  parameter int MAX_POINTS = stip_pkg::MaxPointsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [9:0]          position_i,
  input  logic signed [31:0]  key_value_i,
  input  logic signed [31:0]  data_value_i,
  input  logic                key_missing_i,
  input  logic                data_missing_i,
  output logic                push_o,
  output stip_pkg::item_t     item_o,
  input  logic                q_ready_i
);

  logic            fr_valid_q;
  logic            keep_q;
  stip_pkg::item_t fr_item_q;
  logic            fr_pop;
  logic            fr_free;
  logic            accept;
  stip_pkg::cls_e  cls;
  logic            keep;

  assign fr_pop     = fr_valid_q && (q_ready_i || !keep_q);
  assign fr_free    = !fr_valid_q || fr_pop;
  assign in_stall_o = !fr_free;
  assign accept     = in_valid_i && fr_free;
  assign push_o     = fr_valid_q && keep_q && q_ready_i;
  assign item_o     = fr_item_q;

  always_comb begin
    keep = 1'b1;
    if (operation_i == stip_pkg::OP_LOAD) begin
      cls  = stip_pkg::CLS_LOAD;
      keep = 32'(position_i) < MAX_POINTS;
    end else if (key_missing_i) begin
      cls = stip_pkg::CLS_MISS;
    end else begin
      cls = stip_pkg::CLS_QUERY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else if (accept) begin
      fr_valid_q <= 1'b1;
    end else if (fr_pop) begin
      fr_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keep_q                 <= keep;
      fr_item_q.cls          <= cls;
      fr_item_q.position     <= position_i;
      fr_item_q.key_value    <= key_value_i;
      fr_item_q.data_value   <= data_value_i;
      fr_item_q.key_missing  <= key_missing_i;
      fr_item_q.data_missing <= data_missing_i;
    end
  end

endmodule

// File: design/stip_queue.sv
// ----------------------------------------------------------------------------
// stip_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module stip_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stip_pkg::item_t item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            avail_o,
  output stip_pkg::item_t item_o
);

  stip_pkg::item_t slot_q [2];
  logic            wr_q;
  logic            rd_q;
  logic [1:0]      cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2 || pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

// File: design/stip_back.sv
// ----------------------------------------------------------------------------
// stip_back
// table memories, bisection search, multiply and radix-4 divide, result beat
// ----------------------------------------------------------------------------
module stip_back #(
  parameter int MAX_POINTS = stip_pkg::MaxPointsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stip_pkg::cfg_t      cfg_i,
  input  logic                avail_i,
  input  stip_pkg::item_t     item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  result_value_o,
  output logic [1:0]          status_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_CHK0, S_CHKN, S_BIS, S_BCMP, S_RDVI, S_EQ,
    S_MUL1, S_MUL2, S_BLEND, S_DIV, S_FIN, S_EMIT
  } state_e;

  logic signed [31:0] key_mem [MAX_POINTS];
  logic signed [31:0] val_mem [MAX_POINTS];
  logic [1:0]         mark_mem [MAX_POINTS];

  state_e             state_q;
  stip_pkg::item_t    it_q;
  logic signed [31:0] kd_q, vd_q;
  logic [1:0]         md_q;
  logic [AW-1:0]      i_q, j_q;
  logic signed [31:0] ki_q, kj_q, vi_q, vj_q;
  logic [31:0]        mag_q, dv_q, dx_q, rem_q;
  logic               neg_q;
  logic [63:0]        pq_q;
  logic signed [49:0] p1_q, p2_q;
  logic [4:0]         cnt_q;
  logic signed [31:0] res_q;
  logic [1:0]         st_q;
  logic               ov_q;
  logic signed [31:0] out_res_q;
  logic [1:0]         out_st_q;

  logic               we;
  logic [AW-1:0]      wa, key_ra, val_ra, mark_ra;
  logic [NW-1:0]      n;
  logic [AW-1:0]      nm1;
  logic [AW-1:0]      mid;
  logic               more;
  logic               pos_ok;
  logic [16:0]        fs;
  logic [16:0]        fc;
  logic signed [32:0] dy, dvw, dxw;
  logic [32:0]        r1, r2, r1n, r2n;
  logic               g1, g2;
  logic signed [33:0] base;
  logic signed [50:0] sum;
  logic signed [34:0] bq;
  logic               out_free;

  assign n = (32'(cfg_i.points_used) > MAX_POINTS) ? NW'(MAX_POINTS)
                                                   : NW'(cfg_i.points_used);
  assign nm1    = AW'(n - NW'(1));
  assign mid    = AW'(({1'b0, i_q} + {1'b0, j_q}) >> 1);
  assign more   = ({1'b0, i_q} + {{AW{1'b0}}, 1'b1}) < {1'b0, j_q};
  assign pos_ok = 32'(it_q.position) < MAX_POINTS;
  assign fs     = (cfg_i.step_fraction > 17'd65536) ? 17'd65536 : cfg_i.step_fraction;
  assign fc     = 17'd65536 - fs;

  assign pop_o = (state_q == S_IDLE) && avail_i;
  assign we    = pop_o && (item_i.cls == stip_pkg::CLS_LOAD);
  assign wa    = AW'(item_i.position);
  assign mark_ra = AW'(it_q.position);

  always_comb begin
    key_ra = '0;
    val_ra = j_q;
    case (state_q)
      S_CHK0: key_ra = nm1;
      S_BIS:  key_ra = mid;
      S_RDVI: val_ra = i_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wa]  <= item_i.key_value;
      val_mem[wa]  <= item_i.data_value;
      mark_mem[wa] <= {item_i.data_missing, item_i.key_missing};
    end
    kd_q <= key_mem[key_ra];
    vd_q <= val_mem[val_ra];
    md_q <= mark_mem[mark_ra];
  end

  // interpolation operands
  assign dy  = 33'(vj_q) - 33'(vd_q);
  assign dvw = 33'(it_q.key_value) - 33'(ki_q);
  assign dxw = 33'(kj_q) - 33'(ki_q);

  // two quotient bits per cycle
  assign r1  = {rem_q, pq_q[63]};
  assign g1  = r1 >= {1'b0, dx_q};
  assign r1n = g1 ? r1 - {1'b0, dx_q} : r1;
  assign r2  = {r1n[31:0], pq_q[62]};
  assign g2  = r2 >= {1'b0, dx_q};
  assign r2n = g2 ? r2 - {1'b0, dx_q} : r2;

  assign base = neg_q ? 34'(vi_q) - $signed({2'b00, pq_q[31:0]})
                      : 34'(vi_q) + $signed({2'b00, pq_q[31:0]});
  assign sum  = 51'(p1_q) + 51'(p2_q);
  assign bq   = 35'(sum >>> 16) + 35'((sum < 0) && (sum[15:0] != 16'd0));

  assign out_free       = !ov_q || !out_stall_i;
  assign out_valid_o    = ov_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i && state_q != S_EMIT) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            it_q <= item_i;
            if (item_i.cls == stip_pkg::CLS_MISS) begin
              res_q   <= '0;
              st_q    <= stip_pkg::ST_MISSING;
              state_q <= S_EMIT;
            end else if (item_i.cls == stip_pkg::CLS_QUERY) begin
              state_q <= S_RD0;
            end
          end
        end
        S_RD0: state_q <= S_CHK0;
        S_CHK0: begin
          ki_q    <= kd_q;
          state_q <= S_EMIT;
          res_q   <= '0;
          if (pos_ok && md_q != 2'b00) begin
            st_q <= stip_pkg::ST_MISSING;
          end else if (n == '0) begin
            st_q <= stip_pkg::ST_EMPTY;
          end else if (it_q.key_value < kd_q) begin
            st_q  <= cfg_i.outside_missing ? stip_pkg::ST_MISSING : stip_pkg::ST_VALID;
            res_q <= cfg_i.outside_missing ? 32'sd0 : cfg_i.low_value;
          end else begin
            state_q <= S_CHKN;
          end
        end
        S_CHKN: begin
          kj_q <= kd_q;
          i_q  <= '0;
          j_q  <= nm1;
          if (it_q.key_value > kd_q) begin
            st_q    <= cfg_i.outside_missing ? stip_pkg::ST_MISSING : stip_pkg::ST_VALID;
            res_q   <= cfg_i.outside_missing ? 32'sd0 : cfg_i.high_value;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_BIS;
          end
        end
        S_BIS: begin
          i_q     <= i_q;
          state_q <= more ? S_BCMP : S_RDVI;
          if (more) j_q <= j_q;
        end
        S_BCMP: begin
          if (it_q.key_value < kd_q) begin
            j_q  <= mid;
            kj_q <= kd_q;
          end else begin
            i_q  <= mid;
            ki_q <= kd_q;
          end
          state_q <= S_BIS;
        end
        S_RDVI: begin
          vj_q    <= vd_q;
          state_q <= S_EQ;
        end
        S_EQ: begin
          vi_q  <= vd_q;
          st_q  <= stip_pkg::ST_VALID;
          neg_q <= dy[32];
          mag_q <= dy[32] ? 32'(-dy) : dy[31:0];
          dv_q  <= dvw[31:0];
          dx_q  <= dxw[31:0];
          if (it_q.key_value == kj_q) begin
            res_q   <= vj_q;
            state_q <= S_EMIT;
          end else if (it_q.key_value == ki_q) begin
            res_q   <= vd_q;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          cnt_q <= '0;
          rem_q <= '0;
          if (cfg_i.interpolation_mode) begin
            p1_q    <= vi_q * $signed({1'b0, fc});
            state_q <= S_MUL2;
          end else begin
            pq_q    <= mag_q * dv_q;
            state_q <= S_DIV;
          end
        end
        S_MUL2: begin
          p2_q    <= vj_q * $signed({1'b0, fs});
          state_q <= S_BLEND;
        end
        S_BLEND: begin
          res_q   <= bq[31:0];
          state_q <= S_EMIT;
        end
        S_DIV: begin
          rem_q <= r2n[31:0];
          pq_q  <= {pq_q[61:0], g1, g2};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= S_FIN;
        end
        S_FIN: begin
          if (rem_q != '0 && !neg_q && base < 0) res_q <= 32'(base + 34'sd1);
          else if (rem_q != '0 && neg_q && base > 0) res_q <= 32'(base - 34'sd1);
          else res_q <= base[31:0];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            ov_q      <= 1'b1;
            out_res_q <= res_q;
            out_st_q  <= st_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dx_q != '0) else $error("zero divisor");
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> pq_q[63:32] == '0) else $error("quotient overflow");
  a_bis_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BCMP |-> i_q < j_q) else $error("bisection bounds crossed");
`endif

endmodule

// File: design/sorted_table_interpolator.sv
// ----------------------------------------------------------------------------
// sorted_table_interpolator
// piecewise linear or fraction blend lookup over a loaded table, bisection search
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  operation, position, key, data, marks
//   out      output     out_valid_o/out_stall_i result_value, status
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a load is written to the tables as it leaves the queue; a query runs a bisection search,
// then the radix-4 divider in linear mode or a two-product blend in constant mode
// one memory read port per table sets the bisection pace
// table contents are undefined after reset; control and cfg registers reset to zero
// a stalled result beat holds while the next item is already being worked
// ----------------------------------------------------------------------------
module sorted_table_interpolator #(
  parameter int MAX_POINTS = stip_pkg::MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [9:0]         position_i,
  input  logic signed [31:0] key_value_i,
  input  logic signed [31:0] data_value_i,
  input  logic               key_missing_i,
  input  logic               data_missing_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  stip_pkg::cfg_t  cfg_q;
  stip_pkg::item_t fr_item, q_item;
  logic            push, q_ready, pop, avail;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stip_pkg::CFG_MODE:     cfg_q.interpolation_mode <= cfg_data_i[0];
        stip_pkg::CFG_FRACTION: cfg_q.step_fraction      <= cfg_data_i[16:0];
        stip_pkg::CFG_POINTS:   cfg_q.points_used        <= cfg_data_i[10:0];
        stip_pkg::CFG_LOW:      cfg_q.low_value          <= cfg_data_i;
        stip_pkg::CFG_HIGH:     cfg_q.high_value         <= cfg_data_i;
        stip_pkg::CFG_OUTSIDE:  cfg_q.outside_missing    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  stip_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .position_i,
    .key_value_i, .data_value_i, .key_missing_i, .data_missing_i,
    .push_o(push), .item_o(fr_item), .q_ready_i(q_ready)
  );

  stip_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(fr_item), .ready_o(q_ready),
    .pop_i(pop), .avail_o(avail), .item_o(q_item)
  );

  stip_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .avail_i(avail), .item_i(q_item),
    .pop_o(pop), .out_valid_o, .out_stall_i, .result_value_o, .status_o
  );

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted table interpolator: loads tables of
// rising (and some unsorted) keys, queries them through both modes and every
// configuration extreme, and checks each result against an in-bench
// bisection and interpolation predictor under random handshake idling
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic               op;
    logic [9:0]         pos;
    logic signed [31:0] key;
    logic signed [31:0] data;
    logic               kmiss;
    logic               dmiss;
  } beat_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } answer_t;

  localparam int Depth = 1024;
  localparam longint KeyMin = -64'sd2147483648;
  localparam longint KeyMax = 64'sd2147483647;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = stip_pkg::OP_LOAD;
  logic [9:0]         pos = '0;
  logic signed [31:0] key = '0;
  logic signed [31:0] data = '0;
  logic               kmiss = 1'b0;
  logic               dmiss = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = stip_pkg::CFG_MODE;
  logic [31:0]        cfg_data = '0;

  sorted_table_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (op),
    .position_i     (pos),
    .key_value_i    (key),
    .data_value_i   (data),
    .key_missing_i  (kmiss),
    .data_missing_i (dmiss),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] key_tab [Depth];
  logic signed [31:0] val_tab [Depth];
  logic [1:0]         mark_tab [Depth];
  logic               mode_q;
  int                 frac_q;
  int                 points_q;
  longint             low_q;
  longint             high_q;
  logic               outside_q;

  beat_t   pending [$];
  answer_t answers [$];
  beat_t   cur;
  int      n_in = 0;
  int      n_query = 0;
  int      errors = 0;
  int      hold_left = 0;
  bit      held = 0;
  int      quiet = 0;
  int      send_idle;
  int      recv_idle;

  // stimulus plan
  longint  plan_key [Depth];
  int      loaded = 0;
  int      n_items = 0;

  always_comb begin
    if (n_in < 600) begin
      send_idle = 18;
      recv_idle = 65;
    end else if (n_in < 1200) begin
      send_idle = 65;
      recv_idle = 18;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  function automatic longint interp_linear(longint yi, longint yj, longint xi, longint xj,
                                           longint k);
    longint unsigned dx, dv, mag, prod, q, rm;
    longint dy, b;
    bit neg;
    dx = longint'(xj - xi);
    dv = longint'(k - xi);
    dy = yj - yi;
    neg = dy < 0;
    mag = neg ? -dy : dy;
    prod = mag * dv;
    q = prod / dx;
    rm = prod % dx;
    b = neg ? yi - longint'(q) : yi + longint'(q);
    if (rm != 0) begin
      if (!neg && b < 0) b = b + 1;
      else if (neg && b > 0) b = b - 1;
    end
    return b;
  endfunction

  function automatic answer_t table_lookup(beat_t c);
    answer_t r;
    longint k, f, b;
    int n, i, j, mid;
    r.value = '0;
    r.status = stip_pkg::ST_VALID;
    if (c.kmiss || mark_tab[c.pos] != 0) begin
      r.status = stip_pkg::ST_MISSING;
      return r;
    end
    n = points_q > Depth ? Depth : points_q;
    if (n == 0) begin
      r.status = stip_pkg::ST_EMPTY;
      return r;
    end
    k = c.key;
    i = 0;
    j = n - 1;
    if (k < key_tab[0] || k > key_tab[j]) begin
      if (outside_q) r.status = stip_pkg::ST_MISSING;
      else r.value = 32'((k < key_tab[0]) ? low_q : high_q);
      return r;
    end
    while (i + 1 < j) begin
      mid = (i + j) / 2;
      if (k < key_tab[mid]) j = mid;
      else i = mid;
    end
    if (k == key_tab[j]) r.value = val_tab[j];
    else if (k == key_tab[i]) r.value = val_tab[i];
    else if (mode_q == 1'b0) begin
      r.value = 32'(interp_linear(val_tab[i], val_tab[j], key_tab[i], key_tab[j], k));
    end else begin
      f = frac_q > 65536 ? 65536 : frac_q;
      b = (longint'(val_tab[i]) * (65536 - f) + longint'(val_tab[j]) * f) / 65536;
      r.value = 32'(b);
    end
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      n_in <= n_in + 1;
      if (cur.op == stip_pkg::OP_LOAD) begin
        key_tab[cur.pos] = cur.key;
        val_tab[cur.pos] = cur.data;
        mark_tab[cur.pos] = {cur.dmiss, cur.kmiss};
      end else begin
        answers.push_back(table_lookup(cur));
        n_query <= n_query + 1;
      end
    end
    if (!in_valid || !in_stall) begin
      if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        cur = pending.pop_front();
        op <= cur.op;
        pos <= cur.pos;
        key <= cur.key;
        data <= cur.data;
        kmiss <= cur.kmiss;
        dmiss <= cur.dmiss;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (!held && n_query >= 100) begin
      hold_left <= 500;
      held <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    answer_t e;
    if (out_valid && !out_stall) begin
      if (answers.size() == 0) begin
        if (errors < 10) $display("unexpected result beat: value %0d status %0d",
                                  result_value, status);
        errors <= errors + 1;
      end else begin
        e = answers.pop_front();
        if (e.value !== result_value || e.status !== status) begin
          if (errors < 10) $display("mismatch: expected value %0d status %0d, got %0d %0d",
                                    e.value, e.status, result_value, status);
          errors <= errors + 1;
        end
      end
    end
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == 5000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      stip_pkg::CFG_MODE:     mode_q = value[0];
      stip_pkg::CFG_FRACTION: frac_q = int'(value[16:0]);
      stip_pkg::CFG_POINTS:   points_q = int'(value[10:0]);
      stip_pkg::CFG_LOW:      low_q = longint'($signed(value));
      stip_pkg::CFG_HIGH:     high_q = longint'($signed(value));
      stip_pkg::CFG_OUTSIDE:  outside_q = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(bit m, int f, int pts, longint lo, longint hi, bit om);
    write_reg(stip_pkg::CFG_MODE, 32'(m));
    write_reg(stip_pkg::CFG_FRACTION, 32'(f));
    write_reg(stip_pkg::CFG_POINTS, 32'(pts));
    write_reg(stip_pkg::CFG_LOW, lo[31:0]);
    write_reg(stip_pkg::CFG_HIGH, hi[31:0]);
    write_reg(stip_pkg::CFG_OUTSIDE, 32'(om));
  endtask

  task automatic drain;
    do @(posedge clk_i); while (pending.size() > 0 || in_valid || answers.size() > 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic push_load(int p, longint k, longint d, bit km, bit dm);
    beat_t b;
    b.op = stip_pkg::OP_LOAD;
    b.pos = 10'(p);
    b.key = k[31:0];
    b.data = d[31:0];
    b.kmiss = km;
    b.dmiss = dm;
    pending.push_back(b);
    plan_key[p] = k;
    if (p + 1 > loaded) loaded = p + 1;
    n_items++;
  endtask

  task automatic push_query(longint k, int p, bit km);
    beat_t b;
    b.op = stip_pkg::OP_QUERY;
    b.pos = 10'(p);
    b.key = k[31:0];
    b.data = $urandom();
    b.kmiss = km;
    b.dmiss = 1'($urandom_range(0, 1));
    pending.push_back(b);
    n_items++;
  endtask

  // shape 0 sorted, 1 full key span, 2 unsorted, 3 sorted with repeated keys
  task automatic load_table(int n, int shape);
    longint lo, stride, k, d;
    bit km, dm;
    stride = $urandom_range(1, 1 << 20);
    lo = longint'($urandom_range(0, 1 << 30)) - (64'sd1 << 30);
    for (int i = 0; i < n; i++) begin
      case (shape)
        1: k = KeyMin + i * ((KeyMax - KeyMin) / (n > 1 ? n - 1 : 1));
        2: k = longint'($signed($urandom()));
        default: k = lo + i * stride + $urandom_range(0, stride - 1);
      endcase
      if (shape == 3 && i > 0 && $urandom_range(0, 3) == 0) k = plan_key[i - 1];
      d = $urandom_range(0, 1) ? longint'($signed($urandom()))
                                : longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      km = $urandom_range(0, 19) == 0;
      dm = $urandom_range(0, 19) == 0;
      push_load(i, k, d, km, dm);
    end
  endtask

  function automatic longint pick_key(int n);
    int idx;
    longint k, gap;
    if (n == 0) return longint'($signed($urandom()));
    idx = $urandom_range(0, n - 1);
    case ($urandom_range(0, 5))
      0: k = plan_key[idx];
      1: begin
        k = plan_key[idx];
        if (idx < n - 1) begin
          gap = plan_key[idx + 1] - plan_key[idx];
          if (gap > 0) k = k + $urandom_range(0, gap[31:0]);
        end
      end
      2: k = plan_key[0] - $urandom_range(1, 1000);
      3: k = plan_key[n - 1] + $urandom_range(1, 1000);
      default: k = longint'($signed($urandom()));
    endcase
    if (k < KeyMin) k = KeyMin;
    if (k > KeyMax) k = KeyMax;
    return k;
  endfunction

  initial begin
    int n, pts, nq, fr;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: linear mode, eight points, outside values at the extremes
    set_config(0, 0, 8, KeyMin, KeyMax, 0);
    load_table(8, 0);
    push_load(9, 0, 0, 0, 1);
    push_query(plan_key[0] - 5, 0, 0);
    push_query(plan_key[7] + 5, 1, 0);
    push_query(KeyMin, 2, 0);
    push_query(KeyMax, 1, 0);
    push_query(plan_key[0], 0, 0);
    push_query(plan_key[7], 0, 0);
    push_query(plan_key[4], 0, 0);
    push_query(plan_key[2] + 1, 0, 0);
    push_query(plan_key[5] + 1, 1, 0);
    push_query(plan_key[3], 2, 1);
    push_query(plan_key[3], 9, 0);
    drain();
    // constant blend, fraction one, outside keys missing
    set_config(1, 65536, 8, 0, 0, 1);
    push_query(plan_key[2] + 1, 0, 0);
    push_query(plan_key[0] - 1, 0, 0);
    push_query(plan_key[7] + 1, 0, 0);
    drain();
    // empty table
    set_config(1, 0, 0, 0, 0, 0);
    push_query(plan_key[3], 1, 0);
    push_query(KeyMin, 2, 1);
    drain();
    // full table over the whole key span, oversized count and fraction
    set_config(1, 131071, 2047, KeyMax, KeyMin, 0);
    load_table(Depth, 1);
    for (int i = 0; i < 40; i++) push_query(pick_key(Depth), $urandom_range(0, Depth - 1), 0);
    drain();
    set_config(0, 32768, 1024, 0, 0, 0);
    for (int i = 0; i < 40; i++) push_query(pick_key(Depth), $urandom_range(0, Depth - 1), 0);
    drain();

    while (n_items < 1750) begin
      case ($urandom_range(0, 9))
        0: n = 1;
        1: n = 2;
        default: n = $urandom_range(3, 40);
      endcase
      pts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n;
      fr = ($urandom_range(0, 3) == 0) ? 65536 * $urandom_range(0, 1)
                                        : $urandom_range(0, 131071);
      set_config($urandom_range(0, 1), fr,
                 pts, longint'($signed($urandom())), longint'($signed($urandom())),
                 $urandom_range(0, 3) == 0);
      load_table(n, $urandom_range(0, 3));
      nq = $urandom_range(30, 60);
      for (int i = 0; i < nq; i++)
        push_query(pick_key(pts), $urandom_range(0, loaded - 1), $urandom_range(0, 15) == 0);
      drain();
    end

    drain();
    if (errors == 0 && answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/stip_pkg.sv
design/stip_front.sv
design/stip_queue.sv
design/stip_back.sv
design/sorted_table_interpolator.sv
dv/tb.sv
